### rtl/rbbw_pkg.sv
package rbbw_pkg;

    localparam int WIN_RADIUS_DEF = 3;
    localparam int MAX_LINE_DEF   = 2048;
    localparam int MAX_HEIGHT     = 4096;
    localparam int WIDTH_W        = 12;
    localparam int HEIGHT_W       = 13;
    localparam int PIX_W          = 24;

    localparam logic [0:0] OP_PIXEL = 1'b0;
    localparam logic [0:0] OP_FLUSH = 1'b1;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic rd_issue;
        logic acc_step;
        logic div_start;
        logic out_load;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic has_result;
        logic rd_last;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

### rtl/rbbw_ram.sv
module rbbw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rbbw_ctrl.sv
module rbbw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rbbw_pkg::t_status i_status,
    output rbbw_pkg::t_cmd  o_cmd
);

    rbbw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbbw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rbbw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = rbbw_pkg::ST_READ;
                end
            end
            rbbw_pkg::ST_READ: begin
                // store written at start; results only if window is centered in image
                if (!i_status.has_result) begin
                    o_cmd.advance = 1'b1;
                    n_state = rbbw_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    if (i_status.rd_last) begin
                        n_state = rbbw_pkg::ST_ACC;
                    end
                end
            end
            rbbw_pkg::ST_ACC: begin
                // one more step to take the last read's data
                o_cmd.acc_step = 1'b1;
                n_state = rbbw_pkg::ST_DIV;
                o_cmd.div_start = 1'b1;
            end
            rbbw_pkg::ST_DIV: begin
                if (i_status.div_done && i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.advance  = 1'b1;
                    n_state = rbbw_pkg::ST_IDLE;
                end
            end
            rbbw_pkg::ST_OUT: begin
                n_state = rbbw_pkg::ST_IDLE;
            end
            default: n_state = rbbw_pkg::ST_IDLE;
        endcase
    end

endmodule

### rtl/rbbw_dp.sv
module rbbw_dp #(
    parameter int WIN_RADIUS = rbbw_pkg::WIN_RADIUS_DEF,
    parameter int MAX_LINE   = rbbw_pkg::MAX_LINE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic                           i_cfg_hit,
    input  logic [rbbw_pkg::HEIGHT_W-1:0]  i_cfg_data,
    input  logic                           i_opcode,
    input  logic [7:0]                     i_red_in,
    input  logic [7:0]                     i_green_in,
    input  logic [7:0]                     i_blue_in,
    input  rbbw_pkg::t_cmd                 i_cmd,
    output rbbw_pkg::t_status              o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_red_out,
    output logic [7:0]                     o_green_out,
    output logic [7:0]                     o_blue_out,
    output logic                           o_frame_end
);

    localparam int DIM     = 2 * WIN_RADIUS + 1;
    localparam int TAPS    = DIM * DIM;
    localparam int COL_W   = $clog2(MAX_LINE + WIN_RADIUS + 1);
    localparam int ROW_W   = $clog2(rbbw_pkg::MAX_HEIGHT + WIN_RADIUS + 1);
    localparam int SLOT_W  = $clog2(DIM);
    localparam int XADDR_W = $clog2(MAX_LINE);
    localparam int DEPTH   = DIM * MAX_LINE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int TAP_W   = $clog2(TAPS + 1);
    localparam int SUM_W   = 8 + TAP_W;
    localparam int CNT_W   = TAP_W;

    logic [rbbw_pkg::WIDTH_W-1:0]  r_width;
    logic [rbbw_pkg::HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]              r_col;
    logic [ROW_W-1:0]              r_row;
    logic [SLOT_W-1:0]             r_slot;  // r_row mod DIM

    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        if (r_width == '0) begin
            w_eff = COL_W'(1);
        end else if (COL_W'(r_width) > COL_W'(MAX_LINE)) begin
            w_eff = COL_W'(MAX_LINE);
        end else begin
            w_eff = COL_W'(r_width);
        end
        if (r_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (ROW_W'(r_height) > ROW_W'(rbbw_pkg::MAX_HEIGHT)) begin
            h_eff = ROW_W'(rbbw_pkg::MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(r_height);
        end
    end

    // item latched at start
    logic             r_has;
    logic [COL_W-1:0] r_ox;
    logic [ROW_W-1:0] r_oy;
    logic [SLOT_W-1:0] r_oslot;  // slot of oy

    logic in_img_now;
    assign in_img_now = (r_col < w_eff) && (r_row < h_eff);

    logic has_now;
    assign has_now = (r_col >= COL_W'(WIN_RADIUS)) && (r_row >= ROW_W'(WIN_RADIUS))
        && ((r_col - COL_W'(WIN_RADIUS)) < w_eff) && ((r_row - ROW_W'(WIN_RADIUS)) < h_eff);

    logic [SLOT_W-1:0] oslot_now;
    assign oslot_now = (r_slot >= SLOT_W'(WIN_RADIUS)) ? r_slot - SLOT_W'(WIN_RADIUS)
                                                       : r_slot + SLOT_W'(WIN_RADIUS + 1);

    // window read walker
    logic signed [4:0] r_dy, r_dx;
    logic              r_pend;   // read issued last cycle
    logic              r_pend_ok;

    logic signed [ROW_W+1:0] yy;
    logic signed [COL_W+1:0] xx;
    logic [SLOT_W-1:0]       yslot;
    assign yy = $signed({2'b0, r_oy}) + (ROW_W+2)'(r_dy);
    assign xx = $signed({2'b0, r_ox}) + (COL_W+2)'(r_dx);

    always_comb begin
        if (r_dy < 0) begin
            yslot = (r_oslot >= SLOT_W'(-r_dy)) ? r_oslot - SLOT_W'(-r_dy)
                                                : r_oslot + SLOT_W'(DIM + r_dy);
        end else begin
            yslot = ({1'b0, r_oslot} + (SLOT_W+1)'(r_dy) >= (SLOT_W+1)'(DIM))
                ? r_oslot + SLOT_W'(r_dy) - SLOT_W'(DIM) : r_oslot + SLOT_W'(r_dy);
        end
    end

    logic tap_ok;
    assign tap_ok = (yy >= 0) && (yy < $signed({2'b0, h_eff}))
                 && (xx >= 0) && (xx < $signed({2'b0, w_eff}));

    logic [ADDR_W-1:0] rd_addr, wr_addr;
    assign rd_addr = ADDR_W'(yslot) * ADDR_W'(MAX_LINE) + ADDR_W'(xx[XADDR_W-1:0]);
    assign wr_addr = ADDR_W'(r_slot) * ADDR_W'(MAX_LINE) + ADDR_W'(r_col[XADDR_W-1:0]);

    logic [23:0] rd_data;
    rbbw_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.start && in_img_now),
        .i_waddr (wr_addr),
        .i_wdata ((i_opcode == rbbw_pkg::OP_PIXEL) ? {i_red_in, i_green_in, i_blue_in} : 24'd0),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    logic [SUM_W-1:0] r_sr, r_sg, r_sb;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_has   <= has_now;
            r_ox    <= r_col - COL_W'(WIN_RADIUS);
            r_oy    <= r_row - ROW_W'(WIN_RADIUS);
            r_oslot <= oslot_now;
            r_dy    <= 5'(-WIN_RADIUS);
            r_dx    <= 5'(-WIN_RADIUS);
            r_sr <= '0; r_sg <= '0; r_sb <= '0; r_cnt <= '0;
        end
        if (i_cmd.rd_issue) begin
            if (r_dx == 5'(WIN_RADIUS)) begin
                r_dx <= 5'(-WIN_RADIUS);
                r_dy <= r_dy + 5'sd1;
            end else begin
                r_dx <= r_dx + 5'sd1;
            end
        end
        if ((i_cmd.rd_issue || i_cmd.acc_step) && r_pend && r_pend_ok) begin
            r_sr  <= r_sr + SUM_W'(rd_data[23:16]);
            r_sg  <= r_sg + SUM_W'(rd_data[15:8]);
            r_sb  <= r_sb + SUM_W'(rd_data[7:0]);
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_issue;
        end
        r_pend_ok <= tap_ok;
    end

    assign o_status.has_result = r_has;
    assign o_status.rd_last    = (r_dy == 5'(WIN_RADIUS)) && (r_dx == 5'(WIN_RADIUS));

    // restoring divider, three channels share the count
    logic [SUM_W-1:0] r_qr, r_qg, r_qb;
    logic [SUM_W-1:0] r_rr, r_rg, r_rb;
    logic [CNT_W-1:0] r_div;
    logic [$clog2(SUM_W+1)-1:0] r_dcnt;
    logic r_busy;

    function automatic logic [2*SUM_W-1:0] div_step(input logic [SUM_W-1:0] rem,
                                                    input logic [SUM_W-1:0] q,
                                                    input logic [CNT_W-1:0] d);
        logic [SUM_W:0] t;
        t = {rem, q[SUM_W-1]};
        if (t >= (SUM_W+1)'(d)) begin
            div_step = {SUM_W'(t - (SUM_W+1)'(d)), q[SUM_W-2:0], 1'b1};
        end else begin
            div_step = {t[SUM_W-1:0], q[SUM_W-2:0], 1'b0};
        end
    endfunction

    logic [2*SUM_W-1:0] sr_n, sg_n, sb_n;
    assign sr_n = div_step(r_rr, r_qr, r_div);
    assign sg_n = div_step(r_rg, r_qg, r_div);
    assign sb_n = div_step(r_rb, r_qb, r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_dcnt <= '0;
        end else if (r_busy) begin
            r_dcnt <= r_dcnt + ($clog2(SUM_W+1))'(1);
            if (r_dcnt == ($clog2(SUM_W+1))'(SUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_cmd.div_start) begin
            // last tap may still be pending: fold it in here
            r_qr  <= r_sr + ((r_pend && r_pend_ok) ? SUM_W'(rd_data[23:16]) : '0);
            r_qg  <= r_sg + ((r_pend && r_pend_ok) ? SUM_W'(rd_data[15:8]) : '0);
            r_qb  <= r_sb + ((r_pend && r_pend_ok) ? SUM_W'(rd_data[7:0]) : '0);
            r_div <= r_cnt + ((r_pend && r_pend_ok) ? CNT_W'(1) : '0);
            r_rr <= '0; r_rg <= '0; r_rb <= '0;
        end else if (r_busy) begin
            {r_rr, r_qr} <= sr_n;
            {r_rg, r_qg} <= sg_n;
            {r_rb, r_qb} <= sb_n;
        end
    end

    logic r_div_go;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_div_go <= 1'b0;
        else          r_div_go <= i_cmd.div_start;
    end

    assign o_status.div_done = !r_busy && !r_div_go && !i_cmd.div_start;
    assign o_status.out_free = !o_out_valid || i_out_ready;

    // output register
    logic r_ovalid;
    logic [7:0] r_ro, r_go, r_bo;
    logic r_fe;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_ro <= r_qr[7:0];
            r_go <= r_qg[7:0];
            r_bo <= r_qb[7:0];
            r_fe <= (r_ox == w_eff - COL_W'(1)) && (r_oy == h_eff - ROW_W'(1));
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_red_out   = r_ro;
    assign o_green_out = r_go;
    assign o_blue_out  = r_bo;
    assign o_frame_end = r_fe;

    // scan position and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rbbw_pkg::WIDTH_W'(640);
            r_height <= rbbw_pkg::HEIGHT_W'(480);
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_hit && i_cfg_idx == rbbw_pkg::REG_WIDTH) begin
                r_width <= i_cfg_data[rbbw_pkg::WIDTH_W-1:0];
            end
            if (i_cfg_hit && i_cfg_idx == rbbw_pkg::REG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (i_cmd.advance) begin
            if (r_col + COL_W'(1) >= w_eff + COL_W'(WIN_RADIUS)) begin
                r_col <= '0;
                if (r_row + ROW_W'(1) >= h_eff + ROW_W'(WIN_RADIUS)) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_slot <= (r_slot == SLOT_W'(DIM - 1)) ? '0 : r_slot + SLOT_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    a_frame_end_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_ovalid) else $error("output not valid after load");
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> r_div != '0) else $error("zero pixel count");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |-> !i_cmd.out_load) else $error("output overrun");

endmodule

### rtl/rgb_box_blur_window_core.sv
// Streaming RGB box blur with an edge-clipped (2R+1)x(2R+1) window. Feed a
// (w+R)x(h+R) raster scan: pixel items at image positions, flush items at the
// R padding columns and rows. A result for position (col-R,row-R) follows each
// item that centers the window inside the image. One item at a time: an item
// with a result is done only after the window walk, the division and any
// output stall (a single-port-read line store walked one tap per cycle, then a
// bit-serial divider for the three channels). Any configuration write restarts
// the frame. Line store: 2R+1 rows of MAX_LINE pixels, no clearing needed.
module rgb_box_blur_window_core #(
    parameter int WIN_RADIUS = rbbw_pkg::WIN_RADIUS_DEF,
    parameter int MAX_LINE   = rbbw_pkg::MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_frame_end
);

    rbbw_pkg::t_cmd    cmd;
    rbbw_pkg::t_status status;

    rbbw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rbbw_dp #(.WIN_RADIUS(WIN_RADIUS), .MAX_LINE(MAX_LINE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_hit   (1'b1),
        .i_cfg_data  (i_cfg_data),
        .i_opcode    (i_opcode),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_frame_end (o_frame_end)
    );

endmodule

### test/tb.sv
module tb;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fend;
    } t_blur_px;

    typedef struct {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         typed;
        t_blur_px   want;
    } t_dir_row;

    localparam int RAD      = rbbw_pkg::WIN_RADIUS_DEF;
    localparam int WDIM     = 2 * RAD + 1;
    localparam int LINE     = rbbw_pkg::MAX_LINE_DEF;
    localparam int DRAIN_CY = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [12:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = rbbw_pkg::OP_PIXEL;
    logic [7:0]  i_red_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_blue_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic        o_frame_end;

    rgb_box_blur_window_core DUT (.*);

    always #1 i_clk = ~i_clk;

    // blur predictor state
    logic [23:0] row_buf [WDIM][LINE];
    logic [11:0] cfg_width = 12'd640;
    logic [12:0] cfg_height = 13'd480;
    int          scan_c = 0;
    int          scan_r = 0;

    t_blur_px    blur_q[$];
    int          n_errors = 0;
    int          n_items = 0;
    int          n_blurs = 0;
    int          n_frames = 0;
    int          n_cfg = 0;
    bit          quiet = 0;
    int          hold_asked = 0;
    int          hold_seen = 0;

    function automatic int eff_w();
        if (cfg_width == 0) return 1;
        if (cfg_width > LINE) return LINE;
        return cfg_width;
    endfunction

    function automatic int eff_h();
        if (cfg_height == 0) return 1;
        if (cfg_height > rbbw_pkg::MAX_HEIGHT) return rbbw_pkg::MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic bit at_image();
        return scan_c < eff_w() && scan_r < eff_h();
    endfunction

    function automatic bit blur_predict(input logic op, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        output t_blur_px res);
        int w, h, ox, oy, yy, xx, cnt;
        int sr, sg, sb;
        bit has;
        logic [23:0] px;
        w = eff_w();
        h = eff_h();
        has = 0;
        res = '0;
        if (scan_c < w && scan_r < h)
            row_buf[scan_r % WDIM][scan_c] = (op == rbbw_pkg::OP_PIXEL) ? {r, g, b} : 24'd0;
        ox = scan_c - RAD;
        oy = scan_r - RAD;
        if (ox >= 0 && oy >= 0 && ox < w && oy < h) begin
            sr = 0; sg = 0; sb = 0; cnt = 0;
            for (int dy = -RAD; dy <= RAD; dy++) begin
                yy = oy + dy;
                if (yy < 0 || yy >= h) continue;
                for (int dx = -RAD; dx <= RAD; dx++) begin
                    xx = ox + dx;
                    if (xx < 0 || xx >= w) continue;
                    px = row_buf[yy % WDIM][xx];
                    sr += px[23:16];
                    sg += px[15:8];
                    sb += px[7:0];
                    cnt++;
                end
            end
            res.red   = 8'(sr / cnt);
            res.green = 8'(sg / cnt);
            res.blue  = 8'(sb / cnt);
            res.fend  = (ox == w - 1 && oy == h - 1);
            has = 1;
        end
        scan_c++;
        if (scan_c >= w + RAD) begin
            scan_c = 0;
            scan_r++;
            if (scan_r >= h + RAD) begin
                scan_r = 0;
                n_frames++;
            end
        end
        return has;
    endfunction

    function automatic int pick_gap();
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input bit typed, input t_blur_px want);
        int gap;
        bit has;
        t_blur_px res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
        has = blur_predict(op, r, g, b, res);
        if (typed) begin
            if (res != want || !has) begin
                $display("%0t: table row exp %h got %h (has=%b) from predictor", $time,
                         want, res, has);
                n_errors++;
            end
            blur_q = {blur_q, want};
        end else if (has) begin
            blur_q = {blur_q, res};
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rbbw_pkg::REG_WIDTH) cfg_width = val[11:0];
        else cfg_height = val;
        scan_c = 0;
        scan_r = 0;
        n_cfg++;
    endtask

    task automatic set_size(input logic [12:0] w, input logic [12:0] h);
        write_reg(rbbw_pkg::REG_WIDTH, w);
        write_reg(rbbw_pkg::REG_HEIGHT, h);
    endtask

    task automatic rand_items(input int cnt);
        logic op;
        logic [7:0] ch [3];
        for (int i = 0; i < cnt; i++) begin
            if (at_image())
                op = ($urandom_range(0, 9) == 0) ? rbbw_pkg::OP_FLUSH : rbbw_pkg::OP_PIXEL;
            else
                op = ($urandom_range(0, 9) == 0) ? rbbw_pkg::OP_PIXEL : rbbw_pkg::OP_FLUSH;
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(0, 7))
                    0: ch[k] = 8'h00;
                    1: ch[k] = 8'hFF;
                    default: ch[k] = 8'($urandom);
                endcase
            end
            send_item(op, ch[0], ch[1], ch[2], 0, '0);
        end
    endtask

    // 1x1 image: a flush on the lone image pixel stores black, pixel items
    // at padding positions are ignored, last one yields the frame-end result
    t_dir_row dir_tab[16] = '{
        '{rbbw_pkg::OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00, 0, '0},
        '{rbbw_pkg::OP_FLUSH, 8'hFF, 8'h00, 8'hFF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'h80, 8'h01, 8'h7F, 0, '0},
        '{rbbw_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hAA, 8'h55, 8'hAA, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'h55, 8'hAA, 8'h55, 0, '0},
        '{rbbw_pkg::OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hFE, 8'hFD, 8'hFB, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hF7, 8'hEF, 8'hDF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hBF, 8'h7F, 8'hFF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '0},
        '{rbbw_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, '{8'h00, 8'h00, 8'h00, 1'b1}}
    };

    // result checker with random back-pressure
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_blur_px want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_blurs++;
                if (blur_q.size() == 0) begin
                    $display("%0t: unexpected result %h %h %h fe=%b", $time,
                             o_red_out, o_green_out, o_blue_out, o_frame_end);
                    n_errors++;
                end else begin
                    want = blur_q.pop_front();
                    if (o_red_out !== want.red) begin
                        $display("%0t: red exp %h got %h", $time, want.red, o_red_out);
                        n_errors++;
                    end
                    if (o_green_out !== want.green) begin
                        $display("%0t: green exp %h got %h", $time, want.green, o_green_out);
                        n_errors++;
                    end
                    if (o_blue_out !== want.blue) begin
                        $display("%0t: blue exp %h got %h", $time, want.blue, o_blue_out);
                        n_errors++;
                    end
                    if (o_frame_end !== want.fend) begin
                        $display("%0t: frame_end exp %b got %b", $time, want.fend,
                                 o_frame_end);
                        n_errors++;
                    end
                end
            end
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                stall_left = 3000;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (quiet || $urandom_range(0, 99) < 70) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 2);
            end
        end
    end

    initial begin
        #6000000;
        $display("timeout with %0d results outstanding", blur_q.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        int w, h, frames, rand_start;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size, partial frame only
        rand_items(60);

        set_size(13'd1, 13'd1);
        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].red, dir_tab[i].green,
                      dir_tab[i].blue, dir_tab[i].typed, dir_tab[i].want);

        rand_start = n_items;
        while (n_items - rand_start < 1400) begin
            case ($urandom_range(0, 9))
                0: begin w = 0; h = $urandom_range(0, 3); end
                1: begin w = $urandom_range(1, 3); h = 0; end
                2: begin w = $urandom_range(14, 24); h = $urandom_range(1, 3); end
                default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 10); end
            endcase
            set_size(13'(w), 13'(h));
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 6) == 0) begin
                // frame cut short by a size change
                rand_items($urandom_range(1, 40));
            end else begin
                if (w == 0) w = 1;
                if (h == 0) h = 1;
                frames = $urandom_range(1, 2);
                for (int f = 0; f < frames; f++) begin
                    if (f == 0 && hold_asked == 0 && n_items - rand_start > 400)
                        hold_asked++;
                    rand_items((w + RAD) * (h + RAD));
                    if ($urandom_range(0, 3) == 0) drain();
                end
            end
            quiet = 0;
        end

        // clamped and maximum sizes, partial frames only
        set_size(13'd4095, 13'd0);
        rand_items(60);
        set_size(13'd1, 13'd8191);
        rand_items(60);
        set_size(13'd2048, 13'd4096);
        rand_items(60);

        drain();
        $display("%0d items, %0d results, %0d full frames, %0d register writes",
                 n_items, n_blurs, n_frames, n_cfg);
        $display("sizes 1x1 up to clamped extremes, flush and pixel items in every role");
        if (n_errors == 0 && blur_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### rgb_box_blur_window_core.f
rtl/rbbw_pkg.sv
rtl/rbbw_ram.sv
rtl/rbbw_ctrl.sv
rtl/rbbw_dp.sv
rtl/rgb_box_blur_window_core.sv
test/tb.sv
